@@ design/pow2_size_class_allocator_core_macros.svh @@
// assertion macros for the power-of-two size class allocator
// no dependencies; included by the checker
`ifndef POW2_SIZE_CLASS_ALLOCATOR_CORE_MACROS_SVH
`define POW2_SIZE_CLASS_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, reset masked
`define P2SCA_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, reset masked
`define P2SCA_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/p2sca_pkg.sv @@
// shared types and constants for the power-of-two size class allocator
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package p2sca_pkg;

  localparam int AddrBits      = 19;
  localparam int NumClassesDef = 20;
  localparam int SizeW         = AddrBits + 1;
  localparam int RszW          = AddrBits + 2;
  localparam int KW            = $clog2(AddrBits + 2);
  localparam int LinkAw        = AddrBits - 3;
  localparam int LinkDepth     = 1 << LinkAw;
  localparam int PaddrW        = 3;
  localparam int PdataW        = 32;

  localparam logic [AddrBits-1:0] HeapBaseRst  = AddrBits'(512);
  localparam logic [AddrBits:0]   HeapLimitRst = SizeW'(1) << AddrBits;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_type_t;

  typedef enum logic {
    ST_OK  = 1'b0,
    ST_OOM = 1'b1
  } status_t;

  typedef enum logic {
    REG_HEAP_BASE  = 1'b0,
    REG_HEAP_LIMIT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    req_type_t             req_type;
    logic [AddrBits:0]     req_size;
    logic [AddrBits-1:0]   block_addr;
  } req_t;

  typedef struct packed {
    logic [AddrBits-1:0]   grant_addr;
    logic [AddrBits+1:0]   rounded_size;
    status_t               status;
    logic [AddrBits:0]     bytes_in_use;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic pop;
  } dp_cmd_t;

  typedef struct packed {
    logic pop_hit;
  } dp_stat_t;

  typedef struct packed {
    logic              we;
    reg_idx_t          idx;
    logic [AddrBits:0] data;
  } cfg_wr_t;

  // log2 of the class block size: round up to 8 bytes, then to a power of two
  function automatic logic [KW-1:0] size_log(input logic [AddrBits:0] req_size);
    logic [AddrBits+1:0] sum;
    logic [AddrBits-2:0] units;
    logic [AddrBits-2:0] m;
    logic [KW-1:0]       k;
    sum   = {1'b0, req_size} + RszW'(7);
    units = sum[AddrBits+1:3];
    if (units == '0) begin
      units = (AddrBits-1)'(1);
    end
    m = units - (AddrBits-1)'(1);
    k = KW'(3);
    for (int i = 0; i < AddrBits - 1; i++) begin
      if (m[i]) begin
        k = KW'(i + 4);
      end
    end
    return k;
  endfunction

endpackage

@@ design/pow2_size_class_allocator_core.sv @@
// top level of the power-of-two size class allocator: apb register port, controller, datapath
// depends on p2sca_pkg, p2sca_ctrl, p2sca_dp
//
//   channel   handshake              payload
//   req       req_valid / req_ready  req (req_type, req_size, block_addr)
//   rsp       rsp_valid / rsp_ready  rsp (grant_addr, rounded_size, status, bytes_in_use)
//   config    psel/penable/pwrite    paddr, pwdata, prdata (heap_base at 0, heap_limit at 4)
//
// every request is latched and classified when accepted, then an execute step updates state
// and loads the result register; the next request is taken after that
// an allocate that pops a list reads the link store in the execute step and updates the head
// in the cycle after, which overlaps the accept of the next request
// a held result stalls the execute cycle until the result register frees up
// synchronous reset clears the class heads, the in-use total, the bump pointer and the config registers;
// the link store is not cleared
`timescale 1ns / 1ps

module pow2_size_class_allocator_core #(
  parameter int NUM_CLASSES = p2sca_pkg::NumClassesDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  p2sca_pkg::req_t               req,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output p2sca_pkg::rsp_t               rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [p2sca_pkg::PaddrW-1:0]  paddr,
  input  logic [p2sca_pkg::PdataW-1:0]  pwdata,
  output logic [p2sca_pkg::PdataW-1:0]  prdata,
  output logic                          pready
);
  import p2sca_pkg::*;

  dp_cmd_t              cmd;
  dp_stat_t             stat;
  cfg_wr_t              cfg;
  reg_idx_t             idx;
  logic [AddrBits-1:0]  heap_base;
  logic [AddrBits:0]    heap_limit;

  assign pready   = 1'b1;
  assign idx      = reg_idx_t'(paddr[PaddrW-1]);
  assign cfg.we   = psel && penable && pwrite && pready;
  assign cfg.idx  = idx;
  assign cfg.data = pwdata[AddrBits:0];

  always_comb begin
    case (idx)
      REG_HEAP_BASE:  prdata = PdataW'(heap_base);
      REG_HEAP_LIMIT: prdata = PdataW'(heap_limit);
      default:        prdata = '0;
    endcase
  end

  p2sca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  p2sca_dp #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg        (cfg),
    .req        (req),
    .rsp        (rsp),
    .heap_base  (heap_base),
    .heap_limit (heap_limit)
  );

endmodule

@@ design/p2sca_ctrl.sv @@
// controller state machine: request accept, execute, list pop, result register valid
// depends on p2sca_pkg
`timescale 1ns / 1ps

module p2sca_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  input  p2sca_pkg::dp_stat_t stat,
  output p2sca_pkg::dp_cmd_t  cmd
);
  import p2sca_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_POP  = 3'b100
  } state_t;

  state_t state, state_next;
  logic   rsp_valid_next;
  logic   out_free;

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE) || (state == S_POP);

  always_comb begin
    cmd.load = req_valid && req_ready;
    cmd.exec = (state == S_EXEC) && out_free;
    cmd.pop  = (state == S_POP);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.load) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_next = stat.pop_hit ? S_POP : S_IDLE;
      end
      S_POP: begin
        state_next = cmd.load ? S_EXEC : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (cmd.exec) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

@@ design/p2sca_dp.sv @@
// datapath: request latch, class heads, link store, bump pointer, in-use total, result register
// depends on p2sca_pkg
`timescale 1ns / 1ps

module p2sca_dp #(
  parameter int NUM_CLASSES = p2sca_pkg::NumClassesDef
) (
  input  logic                            clk,
  input  logic                            rst,
  input  p2sca_pkg::dp_cmd_t              cmd,
  output p2sca_pkg::dp_stat_t             stat,
  input  p2sca_pkg::cfg_wr_t              cfg,
  input  p2sca_pkg::req_t                 req,
  output p2sca_pkg::rsp_t                 rsp,
  output logic [p2sca_pkg::AddrBits-1:0]  heap_base,
  output logic [p2sca_pkg::AddrBits:0]    heap_limit
);
  import p2sca_pkg::*;

  localparam int ClsW = $clog2(NUM_CLASSES);

  // request latch
  logic                 r_free;
  logic [AddrBits-1:0]  r_addr;
  logic [RszW-1:0]      r_size;
  logic [ClsW-1:0]      r_cls;
  logic                 r_cls_ok;

  logic [KW-1:0]        k_in;
  logic [KW-1:0]        cls_full;

  logic [AddrBits-1:0]  heads [NUM_CLASSES];
  logic [AddrBits:0]    bump, bump_next;
  logic [AddrBits:0]    total, total_next;
  rsp_t                 rsp_next;

  logic [AddrBits-1:0]  link_mem [LinkDepth];
  logic [AddrBits-1:0]  link_rdata;

  logic [AddrBits-1:0]  head;
  logic [AddrBits:0]    size_w;
  logic [AddrBits+2:0]  bump_sum;
  logic                 oom;
  logic                 free_go;
  logic                 push;
  logic                 mem_we;
  logic                 mem_re;

  assign k_in     = size_log(req.req_size);
  assign cls_full = k_in - KW'(3);

  assign head     = r_cls_ok ? heads[r_cls] : '0;
  assign size_w   = r_size[AddrBits:0];
  assign bump_sum = {2'b00, bump} + {1'b0, r_size};
  assign oom      = bump_sum >= {2'b00, heap_limit};
  assign free_go  = r_free && (r_addr != '0);
  assign push     = free_go && r_cls_ok;
  assign stat.pop_hit = !r_free && r_cls_ok && (head != '0);
  assign mem_we   = cmd.exec && push;
  assign mem_re   = cmd.exec && stat.pop_hit;

  always_comb begin
    bump_next             = bump;
    total_next            = total;
    rsp_next.grant_addr   = '0;
    rsp_next.status       = ST_OK;
    if (r_free) begin
      if (free_go) total_next = total - size_w;
    end else if (stat.pop_hit) begin
      rsp_next.grant_addr = head;
      total_next          = total + size_w;
    end else if (oom) begin
      rsp_next.status     = ST_OOM;
    end else begin
      rsp_next.grant_addr = bump[AddrBits-1:0];
      bump_next           = bump_sum[AddrBits:0];
      total_next          = total + size_w;
    end
    rsp_next.rounded_size = r_size;
    rsp_next.bytes_in_use = total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        heads[i] <= '0;
      end
      bump       <= {1'b0, HeapBaseRst};
      total      <= '0;
      heap_base  <= HeapBaseRst;
      heap_limit <= HeapLimitRst;
    end else begin
      if (cfg.we) begin
        case (cfg.idx)
          REG_HEAP_BASE: begin
            heap_base <= cfg.data[AddrBits-1:0];
            bump      <= {1'b0, cfg.data[AddrBits-1:0]};
          end
          REG_HEAP_LIMIT: begin
            heap_limit <= cfg.data;
          end
          default: begin
          end
        endcase
      end
      if (cmd.exec) begin
        bump  <= bump_next;
        total <= total_next;
        if (push) heads[r_cls] <= r_addr;
      end
      if (cmd.pop) begin
        heads[r_cls] <= link_rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_free   <= (req.req_type == REQ_FREE);
      r_addr   <= req.block_addr;
      r_size   <= RszW'(1) << k_in;
      r_cls    <= ClsW'(cls_full);
      r_cls_ok <= (32'(cls_full) < 32'(NUM_CLASSES));
    end
    if (cmd.exec) begin
      rsp <= rsp_next;
    end
  end

  // link store, one write and one read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[r_addr[AddrBits-1:3]] <= head;
    end
    if (mem_re) begin
      link_rdata <= link_mem[head[AddrBits-1:3]];
    end
  end

endmodule

@@ design/p2sca_checker.sv @@
// port-level checks for the power-of-two size class allocator, bound to the top level
// depends on p2sca_pkg and pow2_size_class_allocator_core_macros.svh
`timescale 1ns / 1ps
`include "pow2_size_class_allocator_core_macros.svh"

module p2sca_checker (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_ready,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input p2sca_pkg::rsp_t rsp
);
  import p2sca_pkg::*;

  `P2SCA_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "result changed while stalled")
  `P2SCA_ASSERT_NOW(a_oom_zero, clk, rst, rsp_valid && (rsp.status == ST_OOM), rsp.grant_addr == '0, "failed allocate with nonzero grant")
  `P2SCA_ASSERT_NOW(a_size_pow2, clk, rst, rsp_valid, $onehot(rsp.rounded_size) && (rsp.rounded_size[2:0] == 3'b000), "rounded size not a power of two of at least 8")
  `P2SCA_ASSERT_NEXT(a_one_at_a_time, clk, rst, req_valid && req_ready, !req_ready, "request taken in back-to-back cycles")

endmodule

bind pow2_size_class_allocator_core p2sca_checker u_p2sca_checker (.*);
